// File: rtl/core/sfvd_pkg.sv
// Shared constants for the spherical falloff vertex deformer.
package sfvd_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int COORD_FRAC_DEF  = 16;

   // Fraction bits of the normalized distance and of the falloff value.
   localparam int DIST_FRAC  = 16;
   localparam int GAIN_WIDTH = 16;
   localparam int GAIN_FRAC  = 14;

   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_X      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_Y      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_Z      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPHERE_RADIUS = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEFORM_GAIN   = 3'd4;

endpackage

// File: rtl/core/sfvd_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per lane.
module sfvd_sqrt_cell #(
   parameter int NR    = 33,
   parameter int LANES = 2,
   parameter int SW    = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   input  logic [SW-1:0]                     up_side,
   input  logic [LANES-1:0][2*NR-1:0]        up_x,
   input  logic [LANES-1:0][NR+1:0]          up_rem,
   input  logic [LANES-1:0][NR-1:0]          up_root,
   output logic                              dn_valid,
   output logic [SW-1:0]                     dn_side,
   output logic [LANES-1:0][2*NR-1:0]        dn_x,
   output logic [LANES-1:0][NR+1:0]          dn_rem,
   output logic [LANES-1:0][NR-1:0]          dn_root
);

   logic                       valid_ff;
   logic [SW-1:0]              side_ff;
   logic [LANES-1:0][2*NR-1:0] x_ff, x_in;
   logic [LANES-1:0][NR+1:0]   rem_ff, rem_in;
   logic [LANES-1:0][NR-1:0]   root_ff, root_in;

   always_comb begin
      logic [NR+3:0] acc;
      logic [NR+3:0] trial;
      logic [NR+3:0] diff;
      for (int l = 0; l < LANES; l++) begin
         // Bring down the next two bits of the radicand and try a one bit.
         acc   = {up_rem[l], up_x[l][2*NR-1 -: 2]};
         trial = {2'b00, up_root[l], 2'b01};
         diff  = acc - trial;
         if (acc >= trial) begin
            rem_in[l]  = diff[NR+1:0];
            root_in[l] = {up_root[l][NR-2:0], 1'b1};
         end else begin
            rem_in[l]  = acc[NR+1:0];
            root_in[l] = {up_root[l][NR-2:0], 1'b0};
         end
         x_in[l] = {up_x[l][2*NR-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= up_side;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign dn_valid = valid_ff;
   assign dn_side  = side_ff;
   assign dn_x     = x_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;

endmodule

// File: rtl/core/sfvd_div_cell.sv
// One cell of a restoring divider chain: resolves one quotient bit per lane.
module sfvd_div_cell #(
   parameter int DW    = 33,
   parameter int LW    = 32,
   parameter int QW    = 32,
   parameter int LANES = 1,
   parameter int SW    = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        up_valid,
   input  logic [SW-1:0]               up_side,
   input  logic [DW-1:0]               up_den,
   input  logic [LANES-1:0][DW:0]      up_rem,
   input  logic [LANES-1:0][LW-1:0]    up_lo,
   input  logic [LANES-1:0][QW-1:0]    up_q,
   output logic                        dn_valid,
   output logic [SW-1:0]               dn_side,
   output logic [DW-1:0]               dn_den,
   output logic [LANES-1:0][DW:0]      dn_rem,
   output logic [LANES-1:0][LW-1:0]    dn_lo,
   output logic [LANES-1:0][QW-1:0]    dn_q
);

   logic                     valid_ff;
   logic [SW-1:0]            side_ff;
   logic [DW-1:0]            den_ff;
   logic [LANES-1:0][DW:0]   rem_ff, rem_in;
   logic [LANES-1:0][LW-1:0] lo_ff, lo_in;
   logic [LANES-1:0][QW-1:0] q_ff, q_in;

   always_comb begin
      logic [DW+1:0] acc;
      logic [DW+1:0] den_ext;
      logic [DW+1:0] diff;
      den_ext = {2'b00, up_den};
      for (int l = 0; l < LANES; l++) begin
         acc  = {up_rem[l], up_lo[l][LW-1]};
         diff = acc - den_ext;
         if (acc >= den_ext) begin
            rem_in[l] = diff[DW:0];
            q_in[l]   = {up_q[l][QW-2:0], 1'b1};
         end else begin
            rem_in[l] = acc[DW:0];
            q_in[l]   = {up_q[l][QW-2:0], 1'b0};
         end
         lo_in[l] = {up_lo[l][LW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= up_side;
      den_ff  <= up_den;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      q_ff    <= q_in;
   end

   assign dn_valid = valid_ff;
   assign dn_side  = side_ff;
   assign dn_den   = den_ff;
   assign dn_rem   = rem_ff;
   assign dn_lo    = lo_ff;
   assign dn_q     = q_ff;

endmodule

// File: rtl/core/sphere_falloff_vertex_deform_top.sv
// Top level of the spherical falloff vertex deformer.
//
// A vertex request is taken at a rising edge with start high and busy low.
// busy is always low: the block is a pipeline that takes one vertex in
// every cycle, with no gaps, whatever came before.
// Each result is shown for one cycle with rsp_valid high; the receiver
// cannot stall, and results leave in request order.
// In order, a vertex passes the offset, square and sum stages,
// COORD_WIDTH+1 cells of the square root chain (distance and vertex
// length side by side), 17 cells of the normalized distance divider,
// the falloff and pull stages, COORD_WIDTH cells of the three lane
// shift divider, and an output register.
// The csr_ port writes the center, radius and gain registers; the user must
// write it only while no vertex is in flight, as the block does not check this.
// Reset empties the pipeline and loads center 0, radius 1.0 and gain 0.
module sphere_falloff_vertex_deform_top
   import sfvd_pkg::*;
#(
   parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [COORD_WIDTH-1:0]      req_pos_x,
   input  logic [COORD_WIDTH-1:0]      req_pos_y,
   input  logic [COORD_WIDTH-1:0]      req_pos_z,
   input  logic                        req_last_vertex,
   input  logic                        csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [COORD_WIDTH-1:0]      csr_data,
   output logic                        rsp_valid,
   output logic [COORD_WIDTH-1:0]      rsp_new_x,
   output logic [COORD_WIDTH-1:0]      rsp_new_y,
   output logic [COORD_WIDTH-1:0]      rsp_new_z,
   output logic                        rsp_inside_sphere,
   output logic                        rsp_degenerate,
   output logic                        rsp_last_out
);

   localparam int CW = COORD_WIDTH;
   localparam int NR = CW + 1;
   localparam int DQ = DIST_FRAC + 1;

   typedef struct packed {
      logic [2:0][CW-1:0] pos;
      logic [2:0][CW-1:0] pmag;
      logic               last;
      logic               in_sphere;
   } side_a_type;

   typedef struct packed {
      logic [2:0][CW-1:0] pos;
      logic [2:0][CW-1:0] pmag;
      logic               last;
      logic               move;
      logic               degen;
      logic [NR-1:0]      len;
   } side_b_type;

   typedef struct packed {
      logic [2:0][CW-1:0] pos;
      logic               last;
      logic               move;
      logic               degen;
      logic               gneg;
   } side_c_type;

   localparam int SWA = $bits(side_a_type);
   localparam int SWB = $bits(side_b_type);
   localparam int SWC = $bits(side_c_type);

   // Configuration registers.
   logic [CW-1:0]         center_x_ff, center_y_ff, center_z_ff;
   logic [CW-2:0]         radius_ff;
   logic [GAIN_WIDTH-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= (CW-1)'(1) << COORD_FRAC_BITS;
         gain_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X:      center_x_ff <= csr_data;
            CSR_CENTER_Y:      center_y_ff <= csr_data;
            CSR_CENTER_Z:      center_z_ff <= csr_data;
            CSR_SPHERE_RADIUS: radius_ff   <= csr_data[CW-2:0];
            CSR_DEFORM_GAIN:   gain_ff     <= csr_data[GAIN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Stage 1: offsets from the center and magnitudes.
   logic               s1_valid_ff;
   logic [2:0][CW-1:0] s1_pos_ff, s1_dmag_ff, s1_pmag_ff, s1_dmag_in, s1_pmag_in;
   logic               s1_last_ff;
   logic [2:0][CW-1:0] req_pos, cen;

   assign req_pos = {req_pos_z, req_pos_y, req_pos_x};
   assign cen     = {center_z_ff, center_y_ff, center_x_ff};

   always_comb begin
      logic [CW:0]   diff;
      logic [CW:0]   dneg;
      logic [CW-1:0] pneg;
      for (int k = 0; k < 3; k++) begin
         diff = {req_pos[k][CW-1], req_pos[k]} - {cen[k][CW-1], cen[k]};
         dneg = ~diff + 1'b1;
         s1_dmag_in[k] = diff[CW] ? dneg[CW-1:0] : diff[CW-1:0];
         pneg = ~req_pos[k] + 1'b1;
         s1_pmag_in[k] = req_pos[k][CW-1] ? pneg : req_pos[k];
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff  <= req_pos;
      s1_dmag_ff <= s1_dmag_in;
      s1_pmag_ff <= s1_pmag_in;
      s1_last_ff <= req_last_vertex;
   end

   // Stage 2: squares.
   logic                 s2_valid_ff;
   logic [2:0][2*CW-1:0] s2_dsq_ff, s2_lsq_ff;
   logic [2*CW-3:0]      s2_rsq_ff;
   logic [2:0][CW-1:0]   s2_pos_ff, s2_pmag_ff;
   logic                 s2_last_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         s2_dsq_ff[k] <= s1_dmag_ff[k] * s1_dmag_ff[k];
         s2_lsq_ff[k] <= s1_pmag_ff[k] * s1_pmag_ff[k];
      end
      s2_rsq_ff  <= radius_ff * radius_ff;
      s2_pos_ff  <= s1_pos_ff;
      s2_pmag_ff <= s1_pmag_ff;
      s2_last_ff <= s1_last_ff;
   end

   // Stage 3: sums of squares.
   logic               s3_valid_ff;
   logic [2*CW+1:0]    s3_dsum_ff, s3_lsum_ff;
   logic [2*CW-3:0]    s3_rsq_ff;
   logic [2:0][CW-1:0] s3_pos_ff, s3_pmag_ff;
   logic               s3_last_ff;

   always_ff @(posedge clock) begin
      s3_dsum_ff <= {2'b00, s2_dsq_ff[0]} + {2'b00, s2_dsq_ff[1]} + {2'b00, s2_dsq_ff[2]};
      s3_lsum_ff <= {2'b00, s2_lsq_ff[0]} + {2'b00, s2_lsq_ff[1]} + {2'b00, s2_lsq_ff[2]};
      s3_rsq_ff  <= s2_rsq_ff;
      s3_pos_ff  <= s2_pos_ff;
      s3_pmag_ff <= s2_pmag_ff;
      s3_last_ff <= s2_last_ff;
   end

   // Square root chain: lane 0 is the distance to the center, lane 1 the length.
   logic                     sq_valid [0:NR];
   side_a_type               sq_side  [0:NR];
   logic [1:0][2*NR-1:0]     sq_x     [0:NR];
   logic [1:0][NR+1:0]       sq_rem   [0:NR];
   logic [1:0][NR-1:0]       sq_root  [0:NR];

   assign sq_valid[0]          = s3_valid_ff;
   assign sq_side[0].pos       = s3_pos_ff;
   assign sq_side[0].pmag      = s3_pmag_ff;
   assign sq_side[0].last      = s3_last_ff;
   assign sq_side[0].in_sphere = s3_dsum_ff <= {4'b0000, s3_rsq_ff};
   assign sq_x[0]              = {s3_lsum_ff, s3_dsum_ff};
   assign sq_rem[0]            = '0;
   assign sq_root[0]           = '0;

   for (genvar i = 0; i < NR; i++) begin : g_sqrt
      sfvd_sqrt_cell #(
         .NR    (NR),
         .LANES (2),
         .SW    (SWA)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (sq_valid[i]),
         .up_side  (sq_side[i]),
         .up_x     (sq_x[i]),
         .up_rem   (sq_rem[i]),
         .up_root  (sq_root[i]),
         .dn_valid (sq_valid[i+1]),
         .dn_side  (sq_side[i+1]),
         .dn_x     (sq_x[i+1]),
         .dn_rem   (sq_rem[i+1]),
         .dn_root  (sq_root[i+1])
      );
   end

   // Normalized distance divider: dn = dist * 2^16 / radius.
   logic                 nd_valid [0:DQ];
   side_b_type           nd_side  [0:DQ];
   logic [CW-2:0]        nd_den   [0:DQ];
   logic [0:0][CW-1:0]   nd_rem   [0:DQ];
   logic [0:0][DQ-1:0]   nd_lo    [0:DQ];
   logic [0:0][DQ-1:0]   nd_q     [0:DQ];
   logic [NR-1:0]        dist_root, len;
   logic                 degen_now;

   assign dist_root = sq_root[NR][0];
   assign len       = sq_root[NR][1];
   assign degen_now = sq_side[NR].in_sphere && (radius_ff == '0 || len == '0);

   assign nd_valid[0]      = sq_valid[NR];
   assign nd_side[0].pos   = sq_side[NR].pos;
   assign nd_side[0].pmag  = sq_side[NR].pmag;
   assign nd_side[0].last  = sq_side[NR].last;
   assign nd_side[0].move  = sq_side[NR].in_sphere && !degen_now;
   assign nd_side[0].degen = degen_now;
   assign nd_side[0].len   = len;
   assign nd_den[0]        = radius_ff;
   assign nd_rem[0][0]     = dist_root[NR-1:1];
   assign nd_lo[0][0]      = {dist_root[0], DIST_FRAC'(0)};
   assign nd_q[0]          = '0;

   for (genvar i = 0; i < DQ; i++) begin : g_ndiv
      sfvd_div_cell #(
         .DW    (CW - 1),
         .LW    (DQ),
         .QW    (DQ),
         .LANES (1),
         .SW    (SWB)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (nd_valid[i]),
         .up_side  (nd_side[i]),
         .up_den   (nd_den[i]),
         .up_rem   (nd_rem[i]),
         .up_lo    (nd_lo[i]),
         .up_q     (nd_q[i]),
         .dn_valid (nd_valid[i+1]),
         .dn_side  (nd_side[i+1]),
         .dn_den   (nd_den[i+1]),
         .dn_rem   (nd_rem[i+1]),
         .dn_lo    (nd_lo[i+1]),
         .dn_q     (nd_q[i+1])
      );
   end

   // Falloff and pull amount: stage C forms h, the other stages multiply.
   logic             sa_valid_ff, sb_valid_ff, sc_valid_ff, sd_valid_ff, se_valid_ff;
   logic             sf_valid_ff;
   side_b_type       sa_side_ff, sb_side_ff, sc_side_ff, sd_side_ff, se_side_ff;
   logic [DQ-1:0]    sa_dn_ff, sa_d2_ff, sb_d2_ff, sb_d3_ff, sc_h_ff;
   logic [CW-2:0]    sd_m_ff;
   logic [CW-1:0]    se_amag_ff;
   logic [2*DQ-1:0]  sa_prod, sb_prod;
   logic [DQ+2:0]    sc_sum;
   logic [DQ+CW-2:0] sd_prod;
   logic [CW+GAIN_WIDTH-2:0] se_prod;
   logic [GAIN_WIDTH-1:0]    gain_mag, gain_neg;

   assign sa_prod  = nd_q[DQ][0] * nd_q[DQ][0];
   assign sb_prod  = sa_d2_ff * sa_dn_ff;
   // h = 2*d3 - 3*d2 + 1.0, negative values clamp to zero.
   assign sc_sum   = {2'b00, sb_d3_ff, 1'b0} + ((DQ+3)'(1) << DIST_FRAC)
                     - {3'b000, sb_d2_ff} - {2'b00, sb_d2_ff, 1'b0};
   assign sd_prod  = sc_h_ff * radius_ff;
   assign gain_neg = ~gain_ff + 1'b1;
   assign gain_mag = gain_ff[GAIN_WIDTH-1] ? gain_neg : gain_ff;
   assign se_prod  = sd_m_ff * gain_mag;

   // Stage F products and side data for the shift divider.
   logic [2:0][2*CW-1:0] sf_prod_ff;
   side_c_type           sf_side_ff;
   logic [NR-1:0]        sf_len_ff;

   always_ff @(posedge clock) begin
      sa_dn_ff   <= nd_q[DQ][0];
      sa_d2_ff   <= sa_prod[DIST_FRAC+DQ-1:DIST_FRAC];
      sa_side_ff <= nd_side[DQ];
      sb_d2_ff   <= sa_d2_ff;
      sb_d3_ff   <= sb_prod[DIST_FRAC+DQ-1:DIST_FRAC];
      sb_side_ff <= sa_side_ff;
      sc_h_ff    <= sc_sum[DQ+2] ? '0 : sc_sum[DQ-1:0];
      sc_side_ff <= sb_side_ff;
      sd_m_ff    <= sd_prod[DIST_FRAC+CW-2:DIST_FRAC];
      sd_side_ff <= sc_side_ff;
      se_amag_ff <= se_prod[GAIN_FRAC+CW-1:GAIN_FRAC];
      se_side_ff <= sd_side_ff;
      for (int k = 0; k < 3; k++) begin
         sf_prod_ff[k] <= se_side_ff.pmag[k] * se_amag_ff;
      end
      sf_side_ff.pos   <= se_side_ff.pos;
      sf_side_ff.last  <= se_side_ff.last;
      sf_side_ff.move  <= se_side_ff.move;
      sf_side_ff.degen <= se_side_ff.degen;
      sf_side_ff.gneg  <= gain_ff[GAIN_WIDTH-1];
      sf_len_ff        <= se_side_ff.len;
   end

   // Shift divider: |p| * a / |v| for all three coordinates.
   logic                 sh_valid [0:CW];
   side_c_type           sh_side  [0:CW];
   logic [CW:0]          sh_den   [0:CW];
   logic [2:0][CW+1:0]   sh_rem   [0:CW];
   logic [2:0][CW-1:0]   sh_lo    [0:CW];
   logic [2:0][CW-1:0]   sh_q     [0:CW];

   assign sh_valid[0] = sf_valid_ff;
   assign sh_side[0]  = sf_side_ff;
   assign sh_den[0]   = sf_len_ff;
   assign sh_q[0]     = '0;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sh_rem[0][k] = {2'b00, sf_prod_ff[k][2*CW-1:CW]};
         sh_lo[0][k]  = sf_prod_ff[k][CW-1:0];
      end
   end

   for (genvar i = 0; i < CW; i++) begin : g_sdiv
      sfvd_div_cell #(
         .DW    (NR),
         .LW    (CW),
         .QW    (CW),
         .LANES (3),
         .SW    (SWC)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (sh_valid[i]),
         .up_side  (sh_side[i]),
         .up_den   (sh_den[i]),
         .up_rem   (sh_rem[i]),
         .up_lo    (sh_lo[i]),
         .up_q     (sh_q[i]),
         .dn_valid (sh_valid[i+1]),
         .dn_side  (sh_side[i+1]),
         .dn_den   (sh_den[i+1]),
         .dn_rem   (sh_rem[i+1]),
         .dn_lo    (sh_lo[i+1]),
         .dn_q     (sh_q[i+1])
      );
   end

   // Output stage: apply the shift, saturate, and register the result.
   logic               rsp_valid_ff;
   logic [2:0][CW-1:0] rsp_pos_ff, rsp_pos_in;
   logic               rsp_inside_ff, rsp_degen_ff, rsp_last_ff;
   side_c_type         out_side;

   assign out_side = sh_side[CW];

   always_comb begin
      logic [CW+1:0] pe;
      logic [CW+1:0] qe;
      logic [CW+1:0] res;
      logic          neg;
      for (int k = 0; k < 3; k++) begin
         pe  = {{2{out_side.pos[k][CW-1]}}, out_side.pos[k]};
         qe  = {2'b00, sh_q[CW][k]};
         neg = out_side.pos[k][CW-1] ^ out_side.gneg;
         res = neg ? pe + qe : pe - qe;
         if (!out_side.move) begin
            rsp_pos_in[k] = out_side.pos[k];
         end else if ($signed(res) > $signed({3'b000, {(CW-1){1'b1}}})) begin
            rsp_pos_in[k] = {1'b0, {(CW-1){1'b1}}};
         end else if ($signed(res) < $signed({3'b111, {(CW-1){1'b0}}})) begin
            rsp_pos_in[k] = {1'b1, {(CW-1){1'b0}}};
         end else begin
            rsp_pos_in[k] = res[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff    <= rsp_pos_in;
      rsp_inside_ff <= out_side.move;
      rsp_degen_ff  <= out_side.degen;
      rsp_last_ff   <= out_side.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         sa_valid_ff  <= 1'b0;
         sb_valid_ff  <= 1'b0;
         sc_valid_ff  <= 1'b0;
         sd_valid_ff  <= 1'b0;
         se_valid_ff  <= 1'b0;
         sf_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= start && !busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         sa_valid_ff  <= nd_valid[DQ];
         sb_valid_ff  <= sa_valid_ff;
         sc_valid_ff  <= sb_valid_ff;
         sd_valid_ff  <= sc_valid_ff;
         se_valid_ff  <= sd_valid_ff;
         sf_valid_ff  <= se_valid_ff;
         rsp_valid_ff <= sh_valid[CW];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_x         = rsp_pos_ff[0];
   assign rsp_new_y         = rsp_pos_ff[1];
   assign rsp_new_z         = rsp_pos_ff[2];
   assign rsp_inside_sphere = rsp_inside_ff;
   assign rsp_degenerate    = rsp_degen_ff;
   assign rsp_last_out      = rsp_last_ff;

endmodule

// File: verif/sfvd_checker.sv
// Checker for the spherical falloff vertex deformer: mirrors registers, predicts, compares.
`timescale 1ns / 1ps
module sfvd_checker
   import sfvd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [31:0]                req_pos_x,
   input  logic [31:0]                req_pos_y,
   input  logic [31:0]                req_pos_z,
   input  logic                       req_last_vertex,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_data,
   input  logic                       rsp_valid,
   input  logic [31:0]                rsp_new_x,
   input  logic [31:0]                rsp_new_y,
   input  logic [31:0]                rsp_new_z,
   input  logic                       rsp_inside_sphere,
   input  logic                       rsp_degenerate,
   input  logic                       rsp_last_out,
   output int                         fail_count,
   output int                         pending
);

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        in_sphere;
      logic        degen;
      logic        last;
   } vertex_result_t;

   vertex_result_t deformed_q[$];

   logic [31:0] ctr_x, ctr_y, ctr_z;
   logic [30:0] radius;
   logic [15:0] gain;

   assign pending = deformed_q.size();

   function automatic logic [63:0] magnitude(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [127:0] square(input logic [63:0] a);
      return {64'd0, a} * {64'd0, a};
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
      logic [63:0] root;
      logic [63:0] cand;
      root = 0;
      for (int b = 62; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (square(cand) <= x) root = cand;
      end
      return root;
   endfunction

   function automatic logic [31:0] saturate(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -128'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic vertex_result_t deform_vertex(input logic [31:0] px, py, pz,
                                                    input logic last);
      vertex_result_t res;
      longint p [3];
      longint c [3];
      longint g, h, d2s, d3s;
      logic [63:0] r, dist_root, len, dn, d2, d3, m, amag, q;
      logic [127:0] dsq;
      logic signed [127:0] delta, moved;
      p[0] = longint'($signed(px));
      p[1] = longint'($signed(py));
      p[2] = longint'($signed(pz));
      c[0] = longint'($signed(ctr_x));
      c[1] = longint'($signed(ctr_y));
      c[2] = longint'($signed(ctr_z));
      g = longint'($signed(gain));
      r = {33'd0, radius};
      res = '{x: px, y: py, z: pz, in_sphere: 1'b0, degen: 1'b0, last: last};
      dsq = square(magnitude(p[0] - c[0])) + square(magnitude(p[1] - c[1]))
            + square(magnitude(p[2] - c[2]));
      if (dsq <= square(r)) begin
         len = floor_sqrt(square(magnitude(p[0])) + square(magnitude(p[1]))
                          + square(magnitude(p[2])));
         if (r == 0 || len == 0) begin
            res.degen = 1'b1;
         end else begin
            dist_root = floor_sqrt(dsq);
            dn = (dist_root << DIST_FRAC) / r;
            d2 = (dn * dn) >> DIST_FRAC;
            d3 = (d2 * dn) >> DIST_FRAC;
            d2s = longint'(d2);
            d3s = longint'(d3);
            h = 2 * d3s - 3 * d2s + (longint'(1) << DIST_FRAC);
            if (h < 0) h = 0;
            m = (64'(h) * r) >> DIST_FRAC;
            amag = (m * magnitude(g)) >> GAIN_FRAC;
            res.in_sphere = 1'b1;
            for (int k = 0; k < 3; k++) begin
               q = 64'(({64'd0, magnitude(p[k])} * {64'd0, amag}) / {64'd0, len});
               delta = $signed({64'd0, q});
               if ((p[k] < 0) != (g < 0)) delta = -delta;
               moved = 128'(p[k]) - delta;
               if (k == 0) res.x = saturate(moved);
               else if (k == 1) res.y = saturate(moved);
               else res.z = saturate(moved);
            end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want, got);
      $display("%0t: %s expected %h, got %h", $realtime, field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      vertex_result_t want;
      if (reset) begin
         ctr_x  <= '0;
         ctr_y  <= '0;
         ctr_z  <= '0;
         radius <= 31'd1 << COORD_FRAC_DEF;
         gain   <= '0;
         deformed_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CENTER_X:      ctr_x  <= csr_data;
               CSR_CENTER_Y:      ctr_y  <= csr_data;
               CSR_CENTER_Z:      ctr_z  <= csr_data;
               CSR_SPHERE_RADIUS: radius <= csr_data[30:0];
               CSR_DEFORM_GAIN:   gain   <= csr_data[15:0];
               default: ;
            endcase
         end
         if (start && !busy)
            deformed_q.push_back(deform_vertex(req_pos_x, req_pos_y, req_pos_z,
                                               req_last_vertex));
         if (rsp_valid) begin
            if (deformed_q.size() == 0) begin
               $display("%0t: result with no request outstanding", $realtime);
               fail_count++;
            end else begin
               want = deformed_q.pop_front();
               if (rsp_new_x !== want.x) report_mismatch("new_x", want.x, rsp_new_x);
               if (rsp_new_y !== want.y) report_mismatch("new_y", want.y, rsp_new_y);
               if (rsp_new_z !== want.z) report_mismatch("new_z", want.z, rsp_new_z);
               if (rsp_inside_sphere !== want.in_sphere)
                  report_mismatch("inside_sphere", want.in_sphere, rsp_inside_sphere);
               if (rsp_degenerate !== want.degen)
                  report_mismatch("degenerate", want.degen, rsp_degenerate);
               if (rsp_last_out !== want.last)
                  report_mismatch("last_out", want.last, rsp_last_out);
            end
         end
      end
   end

endmodule

// File: verif/sphere_falloff_vertex_deform_top_tb.sv
// Stimulus and verdict for the spherical falloff vertex deformer.
`timescale 1ns / 1ps
module sphere_falloff_vertex_deform_top_tb;
   import sfvd_pkg::*;

   localparam int DRAIN_CYCLES = 110;

   logic clock, reset, start, busy;
   logic [31:0] req_pos_x, req_pos_y, req_pos_z;
   logic req_last_vertex;
   logic csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [31:0] csr_data;
   logic rsp_valid, rsp_inside_sphere, rsp_degenerate, rsp_last_out;
   logic [31:0] rsp_new_x, rsp_new_y, rsp_new_z;
   int fail_count, pending;

   // Current sphere as seen by the stimulus, used to aim vertices inside it.
   longint sph_cx, sph_cy, sph_cz, sph_r;
   bit no_idle;

   sphere_falloff_vertex_deform_top dut (.*);
   sfvd_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
   endtask

   task automatic set_sphere(input logic [31:0] cx, cy, cz, input logic [30:0] r,
                             input logic [15:0] g);
      // Stop sending so the pipeline can drain before the registers change.
      @(negedge clock);
      start <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      write_reg(CSR_CENTER_Z, cz);
      write_reg(CSR_SPHERE_RADIUS, {1'b0, r});
      write_reg(CSR_DEFORM_GAIN, {16'd0, g});
      @(negedge clock);
      csr_we <= 1'b0;
      sph_cx = longint'($signed(cx));
      sph_cy = longint'($signed(cy));
      sph_cz = longint'($signed(cz));
      sph_r  = longint'(r);
   endtask

   task automatic send_vertex(input logic [31:0] x, y, z, input logic last);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 35) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start           <= 1'b1;
      req_pos_x       <= x;
      req_pos_y       <= y;
      req_pos_z       <= z;
      req_last_vertex <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [31:0] near(input longint ctr);
      longint span;
      span = sph_r / 2 + 1;
      return 32'(ctr + longint'($urandom_range(32'(2 * span))) - span);
   endfunction

   task automatic random_vertex();
      int mode;
      mode = $urandom_range(99);
      if (mode < 60)
         send_vertex(near(sph_cx), near(sph_cy), near(sph_cz), $urandom_range(1));
      else if (mode < 66)
         send_vertex(32'(sph_cx), 32'(sph_cy), 32'(sph_cz), $urandom_range(1));
      else if (mode < 70)
         send_vertex('0, '0, '0, $urandom_range(1));
      else
         send_vertex($urandom, $urandom, $urandom, $urandom_range(1));
   endtask

   initial begin
      logic [30:0] r;
      logic [31:0] cx, cy, cz;
      reset = 1'b1;
      start = 1'b0;
      no_idle = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_last_vertex = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      sph_cx = 0;
      sph_cy = 0;
      sph_cz = 0;
      sph_r = 65536;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset sphere: unit radius at the origin, zero gain.
      send_vertex('0, '0, '0, 1'b0);
      send_vertex(32'h0000_8000, '0, '0, 1'b1);
      send_vertex(32'h0002_0000, '0, '0, 1'b0);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);

      set_sphere('0, '0, '0, 31'h7FFF_FFFF, 16'h7FFF);
      send_vertex(32'h4000_0000, '0, '0, 1'b0);
      send_vertex(32'hC000_0000, 32'h1000_0000, 32'hF000_0000, 1'b1);
      send_vertex(32'h7FFF_FFFF, '0, '0, 1'b0);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);

      // Negative gain pushes outward hard enough to saturate.
      set_sphere('0, '0, '0, 31'h7FFF_FFFF, 16'h8000);
      send_vertex(32'h0010_0000, '0, '0, 1'b0);
      send_vertex(32'hFFF0_0000, 32'h0010_0000, 32'h0000_0001, 1'b1);
      send_vertex('0, '0, '0, 1'b0);

      // Zero radius: only the center itself is inside, and it is degenerate.
      set_sphere(32'd5, 32'd6, 32'd7, '0, 16'h4000);
      send_vertex(32'd5, 32'd6, 32'd7, 1'b0);
      send_vertex(32'd5, 32'd6, 32'd8, 1'b1);

      // Extreme center with writes to unused register indexes in between.
      set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0001_0000, 16'h2000);
      write_reg(3'd5, $urandom);
      write_reg(3'd7, $urandom);
      @(negedge clock);
      csr_we <= 1'b0;
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_vertex(32'h8000_8000, 32'h7FFF_8000, 32'h8000_0100, 1'b1);
      send_vertex(32'h8001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);

      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(3))
            0: r = '0;
            1: r = 31'h7FFF_FFFF;
            2: r = 31'($urandom_range(32'h0040_0000, 32'h0000_0100));
            default: r = 31'($urandom);
         endcase
         if ($urandom_range(1)) begin
            cx = $urandom;
            cy = $urandom;
            cz = $urandom;
         end else begin
            cx = 32'($signed(20'($urandom)));
            cy = 32'($signed(20'($urandom)));
            cz = 32'($signed(20'($urandom)));
         end
         set_sphere(cx, cy, cz, r, 16'($urandom));
         no_idle = (phase == 4);
         for (int n = 0; n < 105; n++) random_vertex();
         no_idle = 1'b0;
      end
      @(negedge clock);
      start <= 1'b0;

      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
